@@ sv/ffa_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ffa_pkg
// Shared types and codes for the first-fit extent allocator: request and
// response structs, request kinds, status codes, sequencer states and ALU ops.
// ============================================================================
package ffa_pkg;

    // Fixed field widths
    localparam int LEN_W      = 17;
    localparam int FADDR_W    = 16;
    localparam int FCOUNT_W   = 5;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // Request kinds
    localparam logic [1:0] KIND_ALLOC  = 2'd0;
    localparam logic [1:0] KIND_FREE   = 2'd1;
    localparam logic [1:0] KIND_REINIT = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOFIT = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [LEN_W-1:0]   req_size;
        logic [FADDR_W-1:0] free_addr;
    } req_t;

    typedef struct packed {
        logic [FADDR_W-1:0]  grant_addr;
        logic [1:0]          status;
        logic [FCOUNT_W-1:0] extent_count;
    } rsp_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [4:0] {
        S_BOOT,
        S_IDLE,
        S_LOAD,
        S_A_RD,
        S_A_CMP,
        S_A_UPD,
        S_DROP_RD,
        S_DROP_WR,
        S_F_RD,
        S_F_END,
        S_F_CMP,
        S_F_GROW,
        S_INS_RD,
        S_INS_WR,
        S_F_NXT,
        S_F_NCMP,
        S_F_JOIN,
        S_DONE
    } state_t;

endpackage

@@ sv/first_fit_extent_allocator.sv @@
`timescale 1ns / 1ps
// ============================================================================
// first_fit_extent_allocator
// First-fit free extent allocator with coalescing over a configurable pool.
// ============================================================================
// A request is taken when start is high and busy is low; busy stays high
// until the response, which appears on rsp for exactly one cycle with done
// high and cannot be held off. All work is sequenced through the table's one
// write port, one read port and one shared adder, so timing depends on the
// table walk: allocate scans extents until one is long enough, and moves
// later entries down when an extent empties; free scans for its place,
// grows an extent or moves entries up to insert a new one, then moves
// entries down when neighbors join; reinit reloads the pool as one extent.
// After reset the block is busy for one cycle while it loads the pool.
// ============================================================================
module first_fit_extent_allocator #(
    parameter int MAX_EXTENTS = 16,
    parameter int ADDR_BITS   = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  ffa_pkg::req_t               req,
    output logic                        busy,
    output logic                        done,
    output ffa_pkg::rsp_t               rsp,
    input  logic                        cfg_we,
    input  logic [ffa_pkg::LEN_W-1:0]   cfg_wdata
);
    import ffa_pkg::*;

    localparam int IDX_W = $clog2(MAX_EXTENTS);
    localparam int AW    = ((ADDR_BITS > LEN_W) ? ADDR_BITS : LEN_W) + 1;
    localparam logic [32:0] POOL_CAP = 33'(1) << ADDR_BITS;

    logic [LEN_W-1:0]     pool_size_reg;
    logic [LEN_W-1:0]     load_len;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    logic [ADDR_BITS-1:0] wr_base;
    logic [LEN_W-1:0]     wr_len;
    logic [IDX_W-1:0]     rd_idx;
    logic [ADDR_BITS-1:0] rd_base;
    logic [LEN_W-1:0]     rd_len;
    alu_op_t              alu_op;
    logic [AW-1:0]        alu_a;
    logic [AW-1:0]        alu_b;
    logic [AW-1:0]        alu_res;
    logic                 alu_carry;
    logic                 alu_zero;

    // pool size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg <= LEN_W'(65536);
        end
        else if (cfg_we)
        begin
            pool_size_reg <= cfg_wdata;
        end
    end

    // pool cannot exceed the address space
    assign load_len = (33'(pool_size_reg) > POOL_CAP) ? POOL_CAP[LEN_W-1:0] : pool_size_reg;

    ffa_seq #(
        .MAX_EXTENTS (MAX_EXTENTS),
        .ADDR_BITS   (ADDR_BITS),
        .AW          (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .done      (done),
        .rsp       (rsp),
        .load_len  (load_len),
        .wr_en     (wr_en),
        .wr_idx    (wr_idx),
        .wr_base   (wr_base),
        .wr_len    (wr_len),
        .rd_idx    (rd_idx),
        .rd_base   (rd_base),
        .rd_len    (rd_len),
        .alu_op    (alu_op),
        .alu_a     (alu_a),
        .alu_b     (alu_b),
        .alu_res   (alu_res),
        .alu_carry (alu_carry),
        .alu_zero  (alu_zero)
    );

    ffa_table #(
        .DEPTH  (MAX_EXTENTS),
        .BASE_W (ADDR_BITS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_base (wr_base),
        .wr_len  (wr_len),
        .rd_idx  (rd_idx),
        .rd_base (rd_base),
        .rd_len  (rd_len)
    );

    ffa_alu #(
        .W (AW)
    ) u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .res   (alu_res),
        .carry (alu_carry),
        .zero  (alu_zero)
    );

    // a response only arrives once the sequencer is back to idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("response strobe while sequencer busy");

    // an accepted request always occupies the sequencer
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("request accepted without going busy");

    // table never reports more extents than it holds
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.extent_count <= FCOUNT_W'(MAX_EXTENTS)))
        else $error("extent count beyond table depth");

    // failed requests grant nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status != STAT_OK)) |-> (rsp.grant_addr == '0))
        else $error("nonzero grant on failed request");

endmodule

@@ sv/ffa_alu.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ffa_alu
// Shared add/subtract unit. On subtract, carry is set when a >= b and zero
// flags equal operands.
// ============================================================================
module ffa_alu #(
    parameter int W = 18
) (
    input  ffa_pkg::alu_op_t op,
    input  logic [W-1:0]     a,
    input  logic [W-1:0]     b,
    output logic [W-1:0]     res,
    output logic             carry,
    output logic             zero
);
    import ffa_pkg::*;

    logic [W:0]   sum;
    logic [W-1:0] b_op;

    // one adder, operand inverted for subtract
    assign b_op  = (op == ALU_SUB) ? ~b : b;
    assign sum   = {1'b0, a} + {1'b0, b_op} + {{W{1'b0}}, (op == ALU_SUB)};
    assign res   = sum[W-1:0];
    assign carry = sum[W];
    assign zero  = (sum[W-1:0] == '0);

endmodule

@@ sv/ffa_table.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ffa_table
// Extent table memory: base and length per entry, one write port and one
// read port with registered read data.
// ============================================================================
module ffa_table #(
    parameter int DEPTH  = 16,
    parameter int BASE_W = 16
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_idx,
    input  logic [BASE_W-1:0]          wr_base,
    input  logic [ffa_pkg::LEN_W-1:0]  wr_len,
    input  logic [$clog2(DEPTH)-1:0]   rd_idx,
    output logic [BASE_W-1:0]          rd_base,
    output logic [ffa_pkg::LEN_W-1:0]  rd_len
);
    import ffa_pkg::*;

    logic [BASE_W-1:0] base_mem [DEPTH];
    logic [LEN_W-1:0]  len_mem  [DEPTH];
    logic [BASE_W-1:0] rd_base_reg;
    logic [LEN_W-1:0]  rd_len_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            base_mem[wr_idx] <= wr_base;
            len_mem[wr_idx]  <= wr_len;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_base_reg <= base_mem[rd_idx];
        rd_len_reg  <= len_mem[rd_idx];
    end

    assign rd_base = rd_base_reg;
    assign rd_len  = rd_len_reg;

endmodule

@@ sv/ffa_seq.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ffa_seq
// Request sequencer: scans the extent table one entry at a time through the
// shared ALU, shifts entries on insert and removal, and builds the response.
// ============================================================================
module ffa_seq #(
    parameter int MAX_EXTENTS = 16,
    parameter int ADDR_BITS   = 16,
    parameter int AW          = 18
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request side
    input  logic                              start,
    input  ffa_pkg::req_t                     req,
    output logic                              busy,
    output logic                              done,
    output ffa_pkg::rsp_t                     rsp,
    // pool length for reinit, already clamped
    input  logic [ffa_pkg::LEN_W-1:0]         load_len,
    // table port
    output logic                              wr_en,
    output logic [$clog2(MAX_EXTENTS)-1:0]    wr_idx,
    output logic [ADDR_BITS-1:0]              wr_base,
    output logic [ffa_pkg::LEN_W-1:0]         wr_len,
    output logic [$clog2(MAX_EXTENTS)-1:0]    rd_idx,
    input  logic [ADDR_BITS-1:0]              rd_base,
    input  logic [ffa_pkg::LEN_W-1:0]         rd_len,
    // shared ALU
    output ffa_pkg::alu_op_t                  alu_op,
    output logic [AW-1:0]                     alu_a,
    output logic [AW-1:0]                     alu_b,
    input  logic [AW-1:0]                     alu_res,
    input  logic                              alu_carry,
    input  logic                              alu_zero
);
    import ffa_pkg::*;

    localparam int IDX_W = $clog2(MAX_EXTENTS);
    localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_EXTENTS);

    // saturate a wide sum to the length range
    function automatic logic [LEN_W-1:0] sat_len(input logic [AW-1:0] v);
        logic [LEN_W-1:0] r;
        r = (|v[AW-1:LEN_W]) ? LEN_MAX : v[LEN_W-1:0];
        return r;
    endfunction

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     shift_reg, shift_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic [1:0]           kind_reg, kind_next;
    logic [LEN_W-1:0]     size_reg, size_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [ADDR_BITS-1:0] cur_base_reg, cur_base_next;
    logic [LEN_W-1:0]     cur_len_reg, cur_len_next;
    logic [AW-1:0]        end_reg, end_next;
    logic [ADDR_BITS-1:0] grant_reg, grant_next;
    logic [1:0]           status_reg, status_next;
    logic                 done_reg, done_next;
    rsp_t                 rsp_reg, rsp_next;
    logic [CNT_W-1:0]     idx_inc;
    logic [CNT_W-1:0]     shift_dec;

    assign idx_inc   = idx_reg + CNT_W'(1);
    assign shift_dec = shift_reg - CNT_W'(1);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BOOT;
            idx_reg   <= '0;
            shift_reg <= '0;
            used_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            shift_reg <= shift_next;
            used_reg  <= used_next;
            done_reg  <= done_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        size_reg     <= size_next;
        addr_reg     <= addr_next;
        cur_base_reg <= cur_base_next;
        cur_len_reg  <= cur_len_next;
        end_reg      <= end_next;
        grant_reg    <= grant_next;
        status_reg   <= status_next;
        rsp_reg      <= rsp_next;
    end

    // next state and datapath control
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        shift_next    = shift_reg;
        used_next     = used_reg;
        kind_next     = kind_reg;
        size_next     = size_reg;
        addr_next     = addr_reg;
        cur_base_next = cur_base_reg;
        cur_len_next  = cur_len_reg;
        end_next      = end_reg;
        grant_next    = grant_reg;
        status_next   = status_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        wr_en         = 1'b0;
        wr_idx        = idx_reg[IDX_W-1:0];
        wr_base       = cur_base_reg;
        wr_len        = cur_len_reg;
        rd_idx        = idx_reg[IDX_W-1:0];
        alu_op        = ALU_ADD;
        alu_a         = '0;
        alu_b         = '0;

        case (state_reg)
            // one extent covering the whole pool
            S_BOOT, S_LOAD:
            begin
                wr_en       = 1'b1;
                wr_idx      = '0;
                wr_base     = '0;
                wr_len      = load_len;
                used_next   = (load_len != '0) ? CNT_W'(1) : '0;
                status_next = STAT_OK;
                grant_next  = '0;
                state_next  = (state_reg == S_BOOT) ? S_IDLE : S_DONE;
            end

            S_IDLE:
            begin
                if (start)
                begin
                    kind_next   = req.kind;
                    size_next   = req.req_size;
                    addr_next   = ADDR_BITS'(req.free_addr);
                    idx_next    = '0;
                    grant_next  = '0;
                    status_next = STAT_OK;
                    case (req.kind)
                        KIND_ALLOC:  state_next = S_A_RD;
                        KIND_FREE:   state_next = (req.req_size == '0) ? S_DONE : S_F_RD;
                        KIND_REINIT: state_next = S_LOAD;
                        default:     state_next = S_DONE;
                    endcase
                end
            end

            // allocate: first extent long enough
            S_A_RD:
            begin
                if (idx_reg >= used_reg)
                begin
                    status_next = STAT_NOFIT;
                    grant_next  = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_A_CMP;
                end
            end

            S_A_CMP:
            begin
                alu_op = ALU_SUB;
                alu_a  = AW'(rd_len);
                alu_b  = AW'(size_reg);
                if (alu_carry)
                begin
                    grant_next    = rd_base;
                    cur_base_next = rd_base;
                    cur_len_next  = alu_res[LEN_W-1:0];
                    state_next    = alu_zero ? S_DROP_RD : S_A_UPD;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_A_RD;
                end
            end

            // cut the request from the front of the extent
            S_A_UPD:
            begin
                alu_op     = ALU_ADD;
                alu_a      = AW'(cur_base_reg);
                alu_b      = AW'(size_reg);
                wr_en      = 1'b1;
                wr_base    = alu_res[ADDR_BITS-1:0];
                wr_len     = cur_len_reg;
                state_next = S_DONE;
            end

            // remove entry idx: move later entries down one place
            S_DROP_RD:
            begin
                rd_idx = idx_inc[IDX_W-1:0];
                if (idx_inc >= used_reg)
                begin
                    used_next  = used_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DROP_WR;
                end
            end

            S_DROP_WR:
            begin
                wr_en      = 1'b1;
                wr_base    = rd_base;
                wr_len     = rd_len;
                idx_next   = idx_inc;
                state_next = S_DROP_RD;
            end

            // free: find first extent whose end is at or after the address
            S_F_RD:
            begin
                if (idx_reg >= used_reg)
                begin
                    if (used_reg >= MAX_CNT)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        wr_idx    = used_reg[IDX_W-1:0];
                        wr_base   = addr_reg;
                        wr_len    = size_reg;
                        used_next = used_reg + CNT_W'(1);
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_F_END;
                end
            end

            S_F_END:
            begin
                alu_op        = ALU_ADD;
                alu_a         = AW'(rd_base);
                alu_b         = AW'(rd_len);
                end_next      = alu_res;
                cur_base_next = rd_base;
                cur_len_next  = rd_len;
                state_next    = S_F_CMP;
            end

            S_F_CMP:
            begin
                alu_op = ALU_SUB;
                alu_a  = end_reg;
                alu_b  = AW'(addr_reg);
                if (alu_carry)
                begin
                    if (alu_zero)
                    begin
                        state_next = S_F_GROW;
                    end
                    else if (used_reg >= MAX_CNT)
                    begin
                        status_next = STAT_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        shift_next = used_reg;
                        state_next = S_INS_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_F_RD;
                end
            end

            // freed block ends the extent: extend it
            S_F_GROW:
            begin
                alu_op       = ALU_ADD;
                alu_a        = AW'(cur_len_reg);
                alu_b        = AW'(size_reg);
                cur_len_next = sat_len(alu_res);
                wr_en        = 1'b1;
                wr_len       = sat_len(alu_res);
                state_next   = S_F_NXT;
            end

            // open a hole at idx, moving entries up one place
            S_INS_RD:
            begin
                rd_idx = shift_dec[IDX_W-1:0];
                if (shift_reg == idx_reg)
                begin
                    wr_en         = 1'b1;
                    wr_base       = addr_reg;
                    wr_len        = size_reg;
                    cur_base_next = addr_reg;
                    cur_len_next  = size_reg;
                    used_next     = used_reg + CNT_W'(1);
                    state_next    = S_F_NXT;
                end
                else
                begin
                    state_next = S_INS_WR;
                end
            end

            S_INS_WR:
            begin
                wr_en      = 1'b1;
                wr_idx     = shift_reg[IDX_W-1:0];
                wr_base    = rd_base;
                wr_len     = rd_len;
                shift_next = shift_dec;
                state_next = S_INS_RD;
            end

            // check whether the next extent touches
            S_F_NXT:
            begin
                alu_op = ALU_ADD;
                alu_a  = AW'(cur_base_reg);
                alu_b  = AW'(cur_len_reg);
                rd_idx = idx_inc[IDX_W-1:0];
                if (idx_inc >= used_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    end_next   = alu_res;
                    state_next = S_F_NCMP;
                end
            end

            S_F_NCMP:
            begin
                alu_op = ALU_SUB;
                alu_a  = end_reg;
                alu_b  = AW'(rd_base);
                if (alu_zero)
                begin
                    end_next   = AW'(rd_len);
                    state_next = S_F_JOIN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // absorb the next extent, then remove it
            S_F_JOIN:
            begin
                alu_op     = ALU_ADD;
                alu_a      = AW'(cur_len_reg);
                alu_b      = end_reg;
                wr_en      = 1'b1;
                wr_len     = sat_len(alu_res);
                idx_next   = idx_inc;
                state_next = S_DROP_RD;
            end

            S_DONE:
            begin
                done_next             = 1'b1;
                rsp_next.grant_addr   = FADDR_W'(grant_reg);
                rsp_next.status       = status_reg;
                rsp_next.extent_count = FCOUNT_W'(used_reg);
                state_next            = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for first_fit_extent_allocator.
// ----------------------------------------------------------------------------
// Requests go in through the start/busy handshake. A behavioral copy of the
// free-extent table predicts each response when its request is taken. The
// predicted responses wait in a queue, and each done strobe is checked
// against the oldest one, field by field. Directed requests cover the corner
// cases and a table filled to capacity. A long random run follows, over a
// sweep of pool sizes. That run mixes allocates, frees of live blocks, stray
// frees, reinits and the unused kind, with random gaps between requests.
// ============================================================================
module tb;
    import ffa_pkg::*;

    localparam int MAX_EXT = 16;
    localparam int ADDR_W = 16;
    localparam int unsigned ADDR_SPAN = 1 << ADDR_W;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 225;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req = '0;
    logic busy;
    logic done;
    rsp_t rsp;
    logic cfg_we = 1'b0;
    logic [LEN_W-1:0] cfg_wdata = '0;

    // Predicted state of the free-extent table
    logic [FADDR_W-1:0] free_base [MAX_EXT];
    logic [LEN_W-1:0] free_len [MAX_EXT];
    int free_cnt;
    logic [LEN_W-1:0] pool_units;

    rsp_t pending_rsp [$];
    int unsigned live_base [$];
    int unsigned live_size [$];
    int bad_count = 0;

    first_fit_extent_allocator #(
        .MAX_EXTENTS(MAX_EXT),
        .ADDR_BITS(ADDR_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .req(req),
        .busy(busy),
        .done(done),
        .rsp(rsp),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Table predictor
    // ------------------------------------------------------------------
    function automatic logic [LEN_W-1:0] clip_sum(input int unsigned x, input int unsigned y);
        int unsigned s;
        s = x + y;
        return (s > LEN_MAX) ? LEN_MAX : LEN_W'(s);
    endfunction

    function automatic void tbl_drop(input int pos);
        if (pos >= free_cnt)
            return;
        for (int k = pos; k + 1 < free_cnt; k++)
        begin
            free_base[k] = free_base[k + 1];
            free_len[k] = free_len[k + 1];
        end
        free_cnt--;
        free_base[free_cnt] = '0;
        free_len[free_cnt] = '0;
    endfunction

    function automatic void tbl_insert(input int pos, input logic [FADDR_W-1:0] b,
                                       input int unsigned l);
        if (free_cnt >= MAX_EXT || pos > free_cnt)
            return;
        for (int k = free_cnt; k > pos; k--)
        begin
            free_base[k] = free_base[k - 1];
            free_len[k] = free_len[k - 1];
        end
        free_base[pos] = b;
        free_len[pos] = clip_sum(l, 0);
        free_cnt++;
    endfunction

    function automatic void tbl_load();
        int unsigned p;
        p = pool_units;
        if (p > ADDR_SPAN)
            p = ADDR_SPAN;
        for (int k = 0; k < MAX_EXT; k++)
        begin
            free_base[k] = '0;
            free_len[k] = '0;
        end
        free_cnt = 0;
        if (p != 0)
        begin
            free_len[0] = clip_sum(p, 0);
            free_cnt = 1;
        end
    endfunction

    // first fit: grant the front of the first extent that is large enough
    function automatic logic [1:0] predict_alloc(input int unsigned size,
                                                 output logic [FADDR_W-1:0] grant);
        grant = '0;
        for (int i = 0; i < free_cnt; i++)
        begin
            if (free_len[i] >= size)
            begin
                grant = free_base[i];
                free_base[i] = FADDR_W'(free_base[i] + size);
                free_len[i] = LEN_W'(free_len[i] - size);
                if (free_len[i] == 0)
                    tbl_drop(i);
                return STAT_OK;
            end
        end
        return STAT_NOFIT;
    endfunction

    // ordered insert, merging with the extent ending at addr, then the next one
    function automatic logic [1:0] predict_free(input logic [FADDR_W-1:0] addr,
                                                input int unsigned size);
        int unsigned tail;
        if (size == 0)
            return STAT_OK;
        for (int i = 0; i < free_cnt; i++)
        begin
            tail = free_base[i] + free_len[i];
            if (addr <= tail)
            begin
                if (addr == tail)
                    free_len[i] = clip_sum(free_len[i], size);
                else
                begin
                    if (free_cnt >= MAX_EXT)
                        return STAT_FULL;
                    tbl_insert(i, addr, size);
                end
                tail = free_base[i] + free_len[i];
                if (i + 1 < free_cnt && tail == free_base[i + 1])
                begin
                    free_len[i] = clip_sum(free_len[i], free_len[i + 1]);
                    tbl_drop(i + 1);
                end
                return STAT_OK;
            end
        end
        if (free_cnt >= MAX_EXT)
            return STAT_FULL;
        tbl_insert(free_cnt, addr, size);
        return STAT_OK;
    endfunction

    function automatic rsp_t predict_rsp(input req_t r);
        rsp_t o;
        logic [FADDR_W-1:0] g;
        logic [1:0] st;
        g = '0;
        st = STAT_OK;
        case (r.kind)
            KIND_ALLOC:
            begin
                st = predict_alloc(r.req_size, g);
                if (st != STAT_OK)
                    g = '0;
            end
            KIND_FREE:
                st = predict_free(r.free_addr, r.req_size);
            KIND_REINIT:
                tbl_load();
            default:
                ;
        endcase
        o.grant_addr = g;
        o.status = st;
        o.extent_count = FCOUNT_W'(free_cnt);
        return o;
    endfunction

    function automatic req_t make_req(input logic [1:0] k, input int unsigned size,
                                      input int unsigned addr);
        req_t r;
        r.kind = k;
        r.req_size = LEN_W'(size);
        r.free_addr = FADDR_W'(addr);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request driving
    // ------------------------------------------------------------------
    task automatic issue_request(input req_t r, output rsp_t want);
        @(negedge clk);
        start <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (busy);
        want = predict_rsp(r);
        pending_rsp.push_back(want);
    endtask

    task automatic send(input logic [1:0] k, input int unsigned size, input int unsigned addr);
        rsp_t want;
        issue_request(make_req(k, size, addr), want);
    endtask

    task automatic hold_off(input int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_rsp.size() != 0 || busy)
            @(posedge clk);
    endtask

    // pool size only takes effect on the next reinit
    task automatic set_pool(input logic [LEN_W-1:0] v);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        pool_units = v;
    endtask

    // ------------------------------------------------------------------
    // Response checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                bad_count++;
                if (bad_count <= 10)
                    $display("%0t: response with none pending: grant %h status %0d count %0d",
                             $realtime, rsp.grant_addr, rsp.status, rsp.extent_count);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.grant_addr !== want.grant_addr || rsp.status !== want.status ||
                    rsp.extent_count !== want.extent_count)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("%0t: exp/got grant %h/%h status %0d/%0d count %0d/%0d",
                                 $realtime, want.grant_addr, rsp.grant_addr, want.status,
                                 rsp.status, want.extent_count, rsp.extent_count);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // corner cases from the reset pool of 65536 units
    task automatic test_corner_cases();
        send(KIND_ALLOC, 0, 16'hFFFF);          // zero-size grant from the whole pool
        send(KIND_ALLOC, 65536, 0);             // whole pool: extent empties
        send(KIND_ALLOC, 0, 0);                 // zero size, empty table
        send(KIND_ALLOC, 1, 0);
        send(KIND_FREE, 0, 16'h1234);           // zero-size free
        send(KIND_FREE, 16, 16'h0100);          // into an empty table
        send(KIND_FREE, 16'h0100, 16'h0000);    // insert and join with next
        send(KIND_FREE, 16, 16'hFFF0);          // beyond every extent
        send(KIND_FREE, 17'h1FFFF, 16'h0110);   // merge, length saturates
        send(KIND_ALLOC, 17'h10000, 0);         // base wraps
        send(KIND_ALLOC, 17'h1FFFF, 0);         // no fit
        send(KIND_FREE, 4, 16'h0008);           // overlaps an extent
        send(KIND_UNUSED, 17'h1FFFF, 16'hFFFF);
        send(KIND_REINIT, 17'h1FFFF, 16'hFFFF);
    endtask

    // fill the table to capacity from a one-unit pool
    task automatic test_full_table();
        set_pool(1);
        send(KIND_REINIT, 0, 0);
        for (int k = 1; k < MAX_EXT; k++)
            send(KIND_FREE, 1, 2 * k);
        send(KIND_FREE, 1, 40);                 // needs a new entry: full
        send(KIND_FREE, 1, 1);                  // merge only, joins next
        send(KIND_ALLOC, 1, 0);
    endtask

    // random traffic over a sweep of pool sizes
    task automatic test_random_pools();
        logic [LEN_W-1:0] pools [8];
        int idle_pct [8];
        req_t r;
        rsp_t want;
        int sel;
        int idx;
        int unsigned cap;
        int unsigned size;

        pools = '{17'd65536, 17'd0, 17'd1, 17'd16, 17'd1000, 17'h1FFFF, 17'd65535, 17'd300};
        idle_pct = '{30, 0, 15, 40, 0, 20, 10, 0};
        pools[7] = LEN_W'($urandom_range(2, 70000));

        for (int ph = 0; ph < 8; ph++)
        begin
            set_pool(pools[ph]);
            live_base.delete();
            live_size.delete();
            send(KIND_REINIT, $urandom_range(0, 17'h1FFFF), $urandom);
            cap = (pool_units > ADDR_SPAN) ? ADDR_SPAN : pool_units;
            cap = cap / 24;
            if (cap == 0)
                cap = 1;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                sel = $urandom_range(0, 99);
                idx = -1;
                if (sel < 3)
                    r = make_req(KIND_REINIT, $urandom_range(0, 17'h1FFFF), $urandom);
                else if (sel < 5)
                    r = make_req(KIND_UNUSED, $urandom_range(0, 17'h1FFFF), $urandom);
                else if (sel < 50)
                begin
                    case ($urandom_range(0, 19))
                        0: size = 0;
                        1: size = $urandom_range(0, 17'h1FFFF);
                        default: size = $urandom_range(1, cap);
                    endcase
                    r = make_req(KIND_ALLOC, size, $urandom);
                end
                else if (sel < 88 && live_base.size() != 0)
                begin
                    idx = $urandom_range(0, live_base.size() - 1);
                    r = make_req(KIND_FREE, live_size[idx], live_base[idx]);
                end
                else if ($urandom_range(0, 1) == 0)
                    r = make_req(KIND_FREE, $urandom_range(0, 17'h1FFFF), $urandom);
                else
                    r = make_req(KIND_FREE, $urandom_range(0, 64), $urandom);

                issue_request(r, want);

                // track live blocks so most frees are well formed
                if (r.kind == KIND_REINIT)
                begin
                    live_base.delete();
                    live_size.delete();
                end
                else if (r.kind == KIND_ALLOC && want.status == STAT_OK && r.req_size != 0)
                begin
                    live_base.push_back(want.grant_addr);
                    live_size.push_back(r.req_size);
                end
                else if (idx >= 0 && want.status == STAT_OK)
                begin
                    live_base.delete(idx);
                    live_size.delete(idx);
                end

                if ($urandom_range(1, 100) <= idle_pct[ph])
                    hold_off($urandom_range(1, 13));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        pool_units = 17'd65536;
        tbl_load();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_corner_cases();
        test_full_table();
        test_random_pools();

        drain();
        repeat (20) @(posedge clk);
        if (bad_count == 0)
            $display("first_fit_extent_allocator verification clean");
        else
            $display("first_fit_extent_allocator verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #15_000_000;
        $display("first_fit_extent_allocator verification failed");
        $finish;
    end

endmodule
